// File: rtl/texture_segment_quad_coords_core_defines.svh
`ifndef TEXTURE_SEGMENT_QUAD_COORDS_CORE_DEFINES_SVH
`define TEXTURE_SEGMENT_QUAD_COORDS_CORE_DEFINES_SVH

// implication checked in the same cycle, off while in reset
`define TSQC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after, off while in reset
`define TSQC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tsqc_pkg.sv
package tsqc_pkg;

    localparam int SEG_TAG_W  = 6;
    localparam int SEG_OFF_W  = 12;
    localparam int SEG_SIZE_W = 13;

    // request fields packed: tag, off_x, off_y, w, h, alloc_w, alloc_h
    localparam int S_FIELDS_W = SEG_TAG_W + 2 * SEG_OFF_W + 4 * SEG_SIZE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // signed factor 5*used - 1 and denominator 5*alloc
    localparam int MUL_W = SEG_SIZE_W + 4;
    localparam int DEN_W = SEG_SIZE_W + 3;

    localparam int CFG_ADDR_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RECT_LEFT   = 3'd0,
        CFG_RECT_TOP    = 3'd1,
        CFG_RECT_RIGHT  = 3'd2,
        CFG_RECT_BOTTOM = 3'd3,
        CFG_TEX_WIDTH   = 3'd4,
        CFG_TEX_HEIGHT  = 3'd5,
        CFG_SINGLE_SEG  = 3'd6,
        CFG_TEX_PRESENT = 3'd7
    } cfg_reg_t;

endpackage

// File: rtl/tsqc_prep.sv
module tsqc_prep #(
    parameter int PIXEL_BITS = 13,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   aclk,
    input  logic                                   ld,
    input  logic signed [FRAC_BITS+3:0]            edge_pos,
    input  logic        [PIXEL_BITS-1:0]           tex_size,
    input  logic        [tsqc_pkg::SEG_OFF_W-1:0]  seg_off,
    input  logic        [tsqc_pkg::SEG_SIZE_W-1:0] seg_used,
    input  logic        [tsqc_pkg::SEG_SIZE_W-1:0] seg_alloc,
    input  logic                                   single_seg,
    input  logic                                   tex_present,
    output logic                                   neg,
    output logic [FRAC_BITS+4+tsqc_pkg::MUL_W:0]   num_p,
    output logic [tsqc_pkg::DEN_W:0]               den_p
);
    import tsqc_pkg::*;

    localparam int QB   = FRAC_BITS + 4;
    localparam int MW   = QB + MUL_W - 1;
    localparam int NSW  = MW + 1;
    localparam int NPW  = MW + 2;
    localparam int DPW  = DEN_W + 1;
    localparam int PMW  = QB + PIXEL_BITS + 1;
    localparam int OSW  = SEG_OFF_W + FRAC_BITS + 1;
    localparam int DDW  = ((PMW > OSW) ? PMW : OSW) + 1;

    // stage 0: products
    logic signed [MUL_W-1:0]      fac;
    logic signed [NSW-1:0]        prod_s_reg, prod_s_next;
    logic signed [PMW-1:0]        prod_m_reg, prod_m_next;
    logic signed [QB-1:0]         edge_reg;
    logic [SEG_OFF_W-1:0]         off_reg;
    logic [SEG_SIZE_W-1:0]        used_reg, alloc_reg;
    logic                         single_reg, present_reg;

    always_comb begin
        fac = signed'(MUL_W'(seg_used) + (MUL_W'(seg_used) << 2) - MUL_W'(1));
        prod_s_next = NSW'(edge_pos) * NSW'(fac);
        prod_m_next = PMW'(edge_pos) * signed'(PMW'(tex_size));
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            prod_s_reg  <= prod_s_next;
            prod_m_reg  <= prod_m_next;
            edge_reg    <= edge_pos;
            off_reg     <= seg_off;
            used_reg    <= seg_used;
            alloc_reg   <= seg_alloc;
            single_reg  <= single_seg;
            present_reg <= tex_present;
        end
    end

    // stage 1: pick numerator and denominator
    logic signed [DDW-1:0] dd, off_sh, used_sh;
    logic signed [NSW-1:0] n_reg, n_next;
    logic [DEN_W-1:0]      d_reg, d_next;

    always_comb begin
        off_sh  = signed'(DDW'({off_reg, {FRAC_BITS{1'b0}}}));
        used_sh = signed'(DDW'({used_reg, {FRAC_BITS{1'b0}}}));
        dd      = DDW'(prod_m_reg) - off_sh;
        n_next  = '0;
        d_next  = DEN_W'(1);
        if (!present_reg) begin
            n_next = '0;
            d_next = DEN_W'(1);
        end else if (single_reg) begin
            if (alloc_reg > used_reg) begin
                n_next = prod_s_reg;
                d_next = DEN_W'(alloc_reg) + (DEN_W'(alloc_reg) << 2);
            end else begin
                n_next = NSW'(edge_reg);
                d_next = DEN_W'(1);
            end
        end else if (dd <= 0) begin
            n_next = '0;
            d_next = DEN_W'(1);
        end else if (dd < used_sh) begin
            n_next = NSW'(dd);
            d_next = (alloc_reg != '0) ? DEN_W'(alloc_reg) : DEN_W'(used_reg);
        end else if (alloc_reg != '0) begin
            n_next = signed'(NSW'({used_reg, {FRAC_BITS{1'b0}}}));
            d_next = DEN_W'(alloc_reg);
        end else begin
            n_next = signed'(NSW'(1) << FRAC_BITS);
            d_next = DEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            n_reg <= n_next;
            d_reg <= d_next;
        end
    end

    // stage 2: magnitude
    logic [MW-1:0]    mag_reg;
    logic [DEN_W-1:0] d2_reg;
    logic             neg2_reg;

    always_ff @(posedge aclk) begin
        if (ld) begin
            neg2_reg <= n_reg[NSW-1];
            mag_reg  <= n_reg[NSW-1] ? MW'(-n_reg) : MW'(n_reg);
            d2_reg   <= d_reg;
        end
    end

    // stage 3: rounding offset, 2|n| + d over 2d
    logic [NPW-1:0] np_reg;
    logic [DPW-1:0] dp_reg;
    logic           neg3_reg;

    always_ff @(posedge aclk) begin
        if (ld) begin
            neg3_reg <= neg2_reg;
            np_reg   <= NPW'({mag_reg, 1'b0}) + NPW'(d2_reg);
            dp_reg   <= {d2_reg, 1'b0};
        end
    end

    assign neg   = neg3_reg;
    assign num_p = np_reg;
    assign den_p = dp_reg;

endmodule

// File: rtl/tsqc_div_lane.sv
module tsqc_div_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 ld,
    input  logic                                 neg,
    input  logic [FRAC_BITS+4+tsqc_pkg::MUL_W:0] num_p,
    input  logic [tsqc_pkg::DEN_W:0]             den_p,
    output logic signed [FRAC_BITS+3:0]          coord
);
    import tsqc_pkg::*;

    localparam int QB  = FRAC_BITS + 4;
    localparam int MW  = QB + MUL_W - 1;
    localparam int NPW = MW + 2;
    localparam int DPW = DEN_W + 1;

    logic [NPW-1:0] rem_reg [0:QB];
    logic [QB-1:0]  q_reg   [0:QB];
    logic [DPW-1:0] dp_reg  [0:QB];
    logic           neg_reg [0:QB];
    logic           ovf_reg [0:QB];

    // stage 0: quotient too wide for the result
    always_ff @(posedge aclk) begin
        if (ld) begin
            rem_reg[0] <= num_p;
            q_reg[0]   <= '0;
            dp_reg[0]  <= den_p;
            neg_reg[0] <= neg;
            ovf_reg[0] <= num_p >= NPW'({den_p, {QB{1'b0}}});
        end
    end

    // one quotient bit per stage, msb first
    for (genvar j = 1; j <= QB; j++) begin : g_step
        localparam int BIT = QB - j;
        logic [NPW-1:0] sub;
        logic           take;
        logic [QB-1:0]  q_next;

        always_comb begin
            sub          = NPW'(dp_reg[j-1]) << BIT;
            take         = rem_reg[j-1] >= sub;
            q_next       = q_reg[j-1];
            q_next[BIT]  = take;
        end

        always_ff @(posedge aclk) begin
            if (ld) begin
                rem_reg[j] <= take ? (rem_reg[j-1] - sub) : rem_reg[j-1];
                q_reg[j]   <= q_next;
                dp_reg[j]  <= dp_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    // sign and saturation
    logic [QB-1:0]        q;
    logic signed [QB-1:0] res_reg, res_next;

    always_comb begin
        q = q_reg[QB];
        if (!neg_reg[QB]) begin
            if (ovf_reg[QB] || q[QB-1]) begin
                res_next = signed'({1'b0, {(QB-1){1'b1}}});
            end else begin
                res_next = signed'(q);
            end
        end else begin
            if (ovf_reg[QB] || (q[QB-1] && (|q[QB-2:0]))) begin
                res_next = signed'({1'b1, {(QB-1){1'b0}}});
            end else begin
                res_next = signed'(~q + QB'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            res_reg <= res_next;
        end
    end

    assign coord = res_reg;

endmodule

// File: rtl/texture_segment_quad_coords_core.sv
// Texture segment quad coordinates. Each request describes one texture
// segment (tag, pixel offset, used and allocated size) and yields one
// result: the quad corners in pixels and the u/v coordinates of the image
// rectangle in signed Q4.FRAC_BITS, rounded to nearest and saturated.
// Throughput is one request per clock while the output is not stalled. The
// pipeline has four front-end stages (multiply, select, magnitude, rounding
// offset), one overflow stage, one restoring divider stage per result bit,
// and the output register. The four coordinates use four divider lanes side
// by side. A one-entry skid register on the request side takes a request
// while the output register holds a result not yet taken. Configuration is
// to be written through cfg_wr_en/cfg_addr/cfg_wdata only while the block
// is idle; the block itself does not enforce this.
`include "texture_segment_quad_coords_core_defines.svh"

module texture_segment_quad_coords_core #(
    parameter int PIXEL_BITS = 13,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [tsqc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [((FRAC_BITS+4 > PIXEL_BITS) ? FRAC_BITS+4 : PIXEL_BITS)-1:0] cfg_wdata,
    // request channel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // seg_tag, seg_off_x, seg_off_y, seg_w, seg_h, seg_alloc_w, seg_alloc_h
    input  logic [tsqc_pkg::S_TDATA_W-1:0]        s_tdata,
    // result channel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // out_tag, quad_x0, quad_y0, quad_x1, quad_y1, u_left, u_right, v_top, v_bottom
    output logic [((tsqc_pkg::SEG_TAG_W + 4*PIXEL_BITS + 4*(FRAC_BITS+4) + 7)/8)*8-1:0]
                                                  m_tdata
);
    import tsqc_pkg::*;

    localparam int QB         = FRAC_BITS + 4;
    localparam int M_FIELDS_W = SEG_TAG_W + 4 * PIXEL_BITS + 4 * QB;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int NS         = QB + 6;   // total register stages incl. output
    localparam int NPW        = QB + MUL_W + 1;
    localparam int DPW        = DEN_W + 1;

    typedef struct packed {
        logic [SEG_TAG_W-1:0]  tag;
        logic [PIXEL_BITS-1:0] x0;
        logic [PIXEL_BITS-1:0] y0;
        logic [PIXEL_BITS-1:0] x1;
        logic [PIXEL_BITS-1:0] y1;
    } side_t;

    // configuration registers
    logic signed [QB-1:0]   rect_left_reg, rect_top_reg, rect_right_reg, rect_bottom_reg;
    logic [PIXEL_BITS-1:0]  tex_w_reg, tex_h_reg;
    logic                   single_seg_reg, tex_present_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rect_left_reg   <= '0;
            rect_top_reg    <= '0;
            rect_right_reg  <= '0;
            rect_bottom_reg <= '0;
            tex_w_reg       <= PIXEL_BITS'(1);
            tex_h_reg       <= PIXEL_BITS'(1);
            single_seg_reg  <= 1'b0;
            tex_present_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                CFG_RECT_LEFT:   rect_left_reg   <= signed'(cfg_wdata[QB-1:0]);
                CFG_RECT_TOP:    rect_top_reg    <= signed'(cfg_wdata[QB-1:0]);
                CFG_RECT_RIGHT:  rect_right_reg  <= signed'(cfg_wdata[QB-1:0]);
                CFG_RECT_BOTTOM: rect_bottom_reg <= signed'(cfg_wdata[QB-1:0]);
                CFG_TEX_WIDTH:   tex_w_reg       <= cfg_wdata[PIXEL_BITS-1:0];
                CFG_TEX_HEIGHT:  tex_h_reg       <= cfg_wdata[PIXEL_BITS-1:0];
                CFG_SINGLE_SEG:  single_seg_reg  <= cfg_wdata[0];
                CFG_TEX_PRESENT: tex_present_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // flow control: one global advance, input skid entry
    logic                 en;
    logic [NS-1:0]        v_reg;
    logic                 skid_v_reg;
    logic [S_TDATA_W-1:0] skid_data_reg;
    logic                 src_valid;
    logic [S_TDATA_W-1:0] src_data;

    assign m_tvalid  = v_reg[NS-1];
    assign en        = m_tready || !m_tvalid;
    assign s_tready  = !skid_v_reg;
    assign src_valid = skid_v_reg || s_tvalid;
    assign src_data  = skid_v_reg ? skid_data_reg : s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg      <= '0;
            skid_v_reg <= 1'b0;
        end else if (en) begin
            v_reg      <= {v_reg[NS-2:0], src_valid};
            skid_v_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            skid_v_reg <= 1'b1;   // pipeline stalled, park the request
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_tvalid && s_tready) begin
            skid_data_reg <= s_tdata;
        end
    end

    // request unpacking
    logic [SEG_TAG_W-1:0]  in_tag;
    logic [SEG_OFF_W-1:0]  in_off_x, in_off_y;
    logic [SEG_SIZE_W-1:0] in_w, in_h, in_aw, in_ah;

    assign in_tag   = src_data[SEG_TAG_W-1:0];
    assign in_off_x = src_data[SEG_TAG_W +: SEG_OFF_W];
    assign in_off_y = src_data[SEG_TAG_W + SEG_OFF_W +: SEG_OFF_W];
    assign in_w     = src_data[SEG_TAG_W + 2*SEG_OFF_W +: SEG_SIZE_W];
    assign in_h     = src_data[SEG_TAG_W + 2*SEG_OFF_W + SEG_SIZE_W +: SEG_SIZE_W];
    assign in_aw    = src_data[SEG_TAG_W + 2*SEG_OFF_W + 2*SEG_SIZE_W +: SEG_SIZE_W];
    assign in_ah    = src_data[SEG_TAG_W + 2*SEG_OFF_W + 3*SEG_SIZE_W +: SEG_SIZE_W];

    // tag and pixel corners ride a delay line next to the dividers
    side_t side_reg [0:NS-1];
    side_t side_in;

    always_comb begin
        side_in.tag = in_tag;
        if (tex_present_reg) begin
            side_in.x0 = PIXEL_BITS'(in_off_x);
            side_in.y0 = PIXEL_BITS'(in_off_y);
            side_in.x1 = PIXEL_BITS'(in_off_x) + PIXEL_BITS'(in_w);   // wraps
            side_in.y1 = PIXEL_BITS'(in_off_y) + PIXEL_BITS'(in_h);
        end else begin
            side_in.x0 = '0;
            side_in.y0 = '0;
            side_in.x1 = '0;
            side_in.y1 = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < NS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // four coordinate lanes: u_left, u_right, v_top, v_bottom
    logic signed [QB-1:0]   lane_edge  [0:3];
    logic [PIXEL_BITS-1:0]  lane_tsize [0:3];
    logic [SEG_OFF_W-1:0]   lane_off   [0:3];
    logic [SEG_SIZE_W-1:0]  lane_used  [0:3];
    logic [SEG_SIZE_W-1:0]  lane_alloc [0:3];
    logic                   lane_neg   [0:3];
    logic [NPW-1:0]         lane_np    [0:3];
    logic [DPW-1:0]         lane_dp    [0:3];
    logic signed [QB-1:0]   lane_coord [0:3];

    always_comb begin
        lane_edge[0] = rect_left_reg;
        lane_edge[1] = rect_right_reg;
        lane_edge[2] = rect_top_reg;
        lane_edge[3] = rect_bottom_reg;
        for (int k = 0; k < 4; k++) begin
            lane_tsize[k] = (k < 2) ? tex_w_reg : tex_h_reg;
            lane_off[k]   = (k < 2) ? in_off_x  : in_off_y;
            lane_used[k]  = (k < 2) ? in_w      : in_h;
            lane_alloc[k] = (k < 2) ? in_aw     : in_ah;
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        tsqc_prep #(
            .PIXEL_BITS (PIXEL_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_prep (
            .aclk        (aclk),
            .ld          (en),
            .edge_pos    (lane_edge[g]),
            .tex_size    (lane_tsize[g]),
            .seg_off     (lane_off[g]),
            .seg_used    (lane_used[g]),
            .seg_alloc   (lane_alloc[g]),
            .single_seg  (single_seg_reg),
            .tex_present (tex_present_reg),
            .neg         (lane_neg[g]),
            .num_p       (lane_np[g]),
            .den_p       (lane_dp[g])
        );

        tsqc_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .aclk  (aclk),
            .ld    (en),
            .neg   (lane_neg[g]),
            .num_p (lane_np[g]),
            .den_p (lane_dp[g]),
            .coord (lane_coord[g])
        );
    end

    // result packing, first field in the low bits
    side_t side_out;
    assign side_out = side_reg[NS-1];

    assign m_tdata = M_TDATA_W'({lane_coord[3], lane_coord[2], lane_coord[1], lane_coord[0],
                                 side_out.y1, side_out.x1, side_out.y0, side_out.x0,
                                 side_out.tag});

    // a parked request only exists behind a held result
    `TSQC_ASSERT_IMP(a_skid_behind_result, skid_v_reg, m_tvalid,
        "skid entry full while output register empty")
    // an advancing pipeline picks up any pending request
    `TSQC_ASSERT_NXT(a_request_enters, en && src_valid, v_reg[0],
        "request lost at pipeline entry")
    // with no texture bound every field but the tag is zero
    `TSQC_ASSERT_IMP(a_absent_zero, m_tvalid && !tex_present_reg,
        m_tdata[M_FIELDS_W-1:SEG_TAG_W] == '0,
        "nonzero result with texture absent")

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tsqc_pkg::*;

    localparam int PIX_W    = 13;
    localparam int Q_W      = 20;
    localparam int ONE_Q    = 1 << 16;
    localparam int M_DATA_W = ((SEG_TAG_W + 4 * PIX_W + 4 * Q_W + 7) / 8) * 8;
    localparam int LATENCY  = 26;
    localparam int CYCLE_LIMIT = 600000;
    localparam longint Q_MAX = (1 << (Q_W - 1)) - 1;
    localparam longint Q_MIN = -(1 << (Q_W - 1));

    // one segment request
    typedef struct packed {
        logic [12:0] alloc_h;
        logic [12:0] alloc_w;
        logic [12:0] h;
        logic [12:0] w;
        logic [11:0] off_y;
        logic [11:0] off_x;
        logic [5:0]  tag;
    } seg_req_t;

    // one quad result, field order as on m_tdata, declared from the highest bit down
    typedef struct packed {
        logic [Q_W-1:0]   v_bottom;
        logic [Q_W-1:0]   v_top;
        logic [Q_W-1:0]   u_right;
        logic [Q_W-1:0]   u_left;
        logic [PIX_W-1:0] y1;
        logic [PIX_W-1:0] x1;
        logic [PIX_W-1:0] y0;
        logic [PIX_W-1:0] x0;
        logic [5:0]       tag;
    } quad_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [Q_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // shadow copy of the configuration registers
    logic signed [Q_W-1:0] rect_l = '0, rect_t = '0, rect_r = '0, rect_b = '0;
    logic [PIX_W-1:0] tex_w = 1, tex_h = 1;
    logic single_seg = 1'b0, tex_present = 1'b0;

    seg_req_t pending_segs[$];
    quad_res_t expected_quads[$];
    seg_req_t offered_seg;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit long_hold_req = 0;
    int hold_left = 0;
    int errors = 0;
    int cycles = 0;

    texture_segment_quad_coords_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // round to nearest, ties away from zero; den > 0
    function automatic longint div_nearest(longint num, longint den);
        if (num >= 0) return (2 * num + den) / (2 * den);
        return -((-2 * num + den) / (2 * den));
    endfunction

    // partly filled single segment: scale by (5*used - 1) / (5*alloc)
    function automatic longint single_coord(longint r, longint used, longint alloc);
        if (alloc > used) return div_nearest(r * (5 * used - 1), 5 * alloc);
        return r;
    endfunction

    // rectangle edge mapped into the segment, clamped, then alloc scaled
    function automatic longint segment_coord(longint e, longint tsize, longint off,
                                             longint used, longint alloc);
        longint d;
        d = e * tsize - off * ONE_Q;
        if (d <= 0) return 0;
        if (d < used * ONE_Q)
            return (alloc > 0) ? div_nearest(d, alloc) : div_nearest(d, used);
        return (alloc > 0) ? div_nearest(used * ONE_Q, alloc) : ONE_Q;
    endfunction

    function automatic logic [Q_W-1:0] saturate_q(longint v);
        if (v > Q_MAX) v = Q_MAX;
        if (v < Q_MIN) v = Q_MIN;
        return v[Q_W-1:0];
    endfunction

    function automatic quad_res_t predict_quad(seg_req_t s);
        quad_res_t q;
        longint ul, ur, vt, vb;
        q = '0;
        q.tag = s.tag;
        if (!tex_present) return q;
        q.x0 = PIX_W'(s.off_x);
        q.y0 = PIX_W'(s.off_y);
        q.x1 = PIX_W'(s.off_x + s.w);
        q.y1 = PIX_W'(s.off_y + s.h);
        if (single_seg) begin
            ul = single_coord(rect_l, s.w, s.alloc_w);
            ur = single_coord(rect_r, s.w, s.alloc_w);
            vt = single_coord(rect_t, s.h, s.alloc_h);
            vb = single_coord(rect_b, s.h, s.alloc_h);
        end else begin
            ul = segment_coord(rect_l, tex_w, s.off_x, s.w, s.alloc_w);
            ur = segment_coord(rect_r, tex_w, s.off_x, s.w, s.alloc_w);
            vt = segment_coord(rect_t, tex_h, s.off_y, s.h, s.alloc_h);
            vb = segment_coord(rect_b, tex_h, s.off_y, s.h, s.alloc_h);
        end
        q.u_left = saturate_q(ul);
        q.u_right = saturate_q(ur);
        q.v_top = saturate_q(vt);
        q.v_bottom = saturate_q(vb);
        return q;
    endfunction

    // request driver: holds a request until taken, predicts on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) expected_quads.push_back(predict_quad(offered_seg));
            if (pending_segs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                offered_seg = pending_segs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= S_TDATA_W'(offered_seg);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side ready, with random stalls and one long hold-off
    always @(posedge aclk) begin
        if (long_hold_req) begin
            long_hold_req = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        quad_res_t got, exp_q;
        if (aresetn && m_tvalid && m_tready) begin
            got = quad_res_t'(m_tdata[$bits(quad_res_t)-1:0]);
            if (expected_quads.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_q = expected_quads.pop_front();
                if (got.tag !== exp_q.tag || got.x0 !== exp_q.x0 || got.y0 !== exp_q.y0 ||
                    got.x1 !== exp_q.x1 || got.y1 !== exp_q.y1 ||
                    got.u_left !== exp_q.u_left || got.u_right !== exp_q.u_right ||
                    got.v_top !== exp_q.v_top || got.v_bottom !== exp_q.v_bottom) begin
                    $display("%0t: quad mismatch exp tag=%0d x0=%0d y0=%0d x1=%0d y1=%0d ul=%h ur=%h vt=%h vb=%h",
                             $time, exp_q.tag, exp_q.x0, exp_q.y0, exp_q.x1, exp_q.y1,
                             exp_q.u_left, exp_q.u_right, exp_q.v_top, exp_q.v_bottom);
                    $display("%0t: quad mismatch got tag=%0d x0=%0d y0=%0d x1=%0d y1=%0d ul=%h ur=%h vt=%h vb=%h",
                             $time, got.tag, got.x0, got.y0, got.x1, got.y1,
                             got.u_left, got.u_right, got.v_top, got.v_bottom);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one register write per clock; the caller drops the enable after the last
    task automatic write_reg(cfg_reg_t idx, logic [Q_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_RECT_LEFT:   rect_l = val;
            CFG_RECT_TOP:    rect_t = val;
            CFG_RECT_RIGHT:  rect_r = val;
            CFG_RECT_BOTTOM: rect_b = val;
            CFG_TEX_WIDTH:   tex_w = val[PIX_W-1:0];
            CFG_TEX_HEIGHT:  tex_h = val[PIX_W-1:0];
            CFG_SINGLE_SEG:  single_seg = val[0];
            CFG_TEX_PRESENT: tex_present = val[0];
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(int l, int t, int r, int b, int tw, int th,
                              bit single, bit present);
        write_reg(CFG_RECT_LEFT, Q_W'(l));
        write_reg(CFG_RECT_TOP, Q_W'(t));
        write_reg(CFG_RECT_RIGHT, Q_W'(r));
        write_reg(CFG_RECT_BOTTOM, Q_W'(b));
        write_reg(CFG_TEX_WIDTH, Q_W'(tw));
        write_reg(CFG_TEX_HEIGHT, Q_W'(th));
        write_reg(CFG_SINGLE_SEG, Q_W'(single));
        write_reg(CFG_TEX_PRESENT, Q_W'(present));
        cfg_wr_en <= 1'b0;
    endtask

    // sender pauses until every result is back, then the pipe drains
    task automatic drain();
        while (pending_segs.size() > 0 || s_tvalid || expected_quads.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic int rand_rect();
        case ($urandom_range(9))
            0: return -524288;
            1: return 524287;
            2, 3: return $urandom_range(0, 1 << 20) - (1 << 19);
            default: return $urandom_range(0, ONE_Q);
        endcase
    endfunction

    function automatic int rand_tex();
        case ($urandom_range(5))
            0: return 4096;
            1: return $urandom_range(1, 16);
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic logic [12:0] rand_size();
        case ($urandom_range(7))
            0: return 0;
            1: return 4096;
            2: return $urandom_range(1, 8);
            default: return $urandom_range(0, 4096);
        endcase
    endfunction

    // mostly segments whose offset lies inside the texture, with alloc >= used
    function automatic seg_req_t rand_seg();
        seg_req_t s;
        s.tag = $urandom_range(63);
        s.w = rand_size();
        s.h = rand_size();
        if ($urandom_range(9) < 7) begin
            s.off_x = $urandom_range(0, (tex_w > 4096 || tex_w == 0) ? 4095 : tex_w - 1);
            s.off_y = $urandom_range(0, (tex_h > 4096 || tex_h == 0) ? 4095 : tex_h - 1);
            s.alloc_w = (s.w + $urandom_range(0, 64) > 4096) ? 4096
                                                             : s.w + $urandom_range(0, 64);
            s.alloc_h = (s.h + $urandom_range(0, 64) > 4096) ? 4096
                                                             : s.h + $urandom_range(0, 64);
        end else begin
            s.off_x = $urandom_range(4095);
            s.off_y = $urandom_range(4095);
            s.alloc_w = $urandom_range(3) == 0 ? 13'd0 : rand_size();
            s.alloc_h = $urandom_range(3) == 0 ? 13'd0 : rand_size();
        end
        return s;
    endfunction

    // field extremes, unknown alloc, zero used size, full and partial alloc
    task automatic push_directed();
        pending_segs.push_back('{13'd0, 13'd0, 13'd0, 13'd0, 12'd0, 12'd0, 6'd0});
        pending_segs.push_back('{13'd4096, 13'd4096, 13'd4096, 13'd4096,
                                 12'd4095, 12'd4095, 6'd63});
        pending_segs.push_back('{13'd100, 13'd100, 13'd0, 13'd0, 12'd1, 12'd1, 6'd1});
        pending_segs.push_back('{13'd0, 13'd0, 13'd50, 13'd50, 12'd0, 12'd0, 6'd2});
        pending_segs.push_back('{13'd64, 13'd64, 13'd50, 13'd50, 12'd0, 12'd0, 6'd3});
        pending_segs.push_back('{13'd1, 13'd1, 13'd1, 13'd1, 12'd0, 12'd0, 6'd4});
        pending_segs.push_back('{13'd10, 13'd20, 13'd30, 13'd40, 12'd5, 12'd7, 6'd5});
        pending_segs.push_back('{13'd4096, 13'd4096, 13'd1, 13'd1, 12'd2, 12'd3, 6'd6});
        pending_segs.push_back('{13'd2, 13'd3, 13'd4096, 13'd4096, 12'd0, 12'd0, 6'd7});
        pending_segs.push_back('{13'd8, 13'd8, 13'd16, 13'd16, 12'd16, 12'd16, 6'd8});
        pending_segs.push_back('{13'd0, 13'd4096, 13'd4095, 13'd0, 12'd2048, 12'd0, 6'd9});
        pending_segs.push_back('{13'd3, 13'd5, 13'd2, 13'd4, 12'd1, 12'd2, 6'd10});
    endtask

    initial begin
        int idle_modes[4][2] = '{'{0, 0}, '{68, 0}, '{0, 68}, '{12, 12}};
        int ph;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: texture absent
        for (int i = 0; i < 20; i++) pending_segs.push_back(rand_seg());
        drain();

        // directed under single segment, then multi segment over a 16x16 texture and over a zero-sized one
        set_config(-524288, 524287, ONE_Q, ONE_Q / 2, 16, 16, 1, 1);
        push_directed();
        drain();
        set_config(ONE_Q / 4, 0, ONE_Q, ONE_Q * 3 / 4, 16, 16, 0, 1);
        push_directed();
        drain();
        set_config(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 1);
        push_directed();
        drain();

        // random phases over changing configurations
        for (ph = 0; ph < 16; ph++) begin
            send_idle_pct = idle_modes[ph % 4][0];
            recv_stall_pct = idle_modes[ph % 4][1];
            set_config(rand_rect(), rand_rect(), rand_rect(), rand_rect(),
                       (ph == 5) ? 4096 : rand_tex(), (ph == 5) ? 1 : rand_tex(),
                       (ph % 3) == 1, (ph != 7));
            if (ph == 4) long_hold_req = 1;
            for (int i = 0; i < 94; i++) pending_segs.push_back(rand_seg());
            drain();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tsqc_pkg.sv
rtl/tsqc_prep.sv
rtl/tsqc_div_lane.sv
rtl/texture_segment_quad_coords_core.sv
sim/tb_top.sv
